### sv/utf8_to_wide_char_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// utf8_to_wide_char_decoder_top_defines
// Assertion macros shared by the decoder modules. Both expect clk_i, and
// UTF8D_ASSERT also rst_ni, in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_WIDE_CHAR_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_WIDE_CHAR_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define UTF8D_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every edge, reset included
`define UTF8D_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define UTF8D_ASSERT(name, prop, msg)
`define UTF8D_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### sv/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types, constants and decode helpers of the UTF-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CAP_W       = 11;
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd32;

  // item operations
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // register index taken from the word address
  localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b0;

  // one queue entry: all results that a single input item causes
  typedef struct packed {
    logic [1:0]        n_chars;
    logic [CP_W-1:0]   cp0;
    logic [CP_W-1:0]   cp1;
    logic [SLOT_W-1:0] slot;
    logic              term;
    logic [SLOT_W-1:0] term_slot;
  } job_t;

  // sequence length from a lead byte, 0 when it fits no pattern
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // pack lead payload and continuation payloads into a code point
  function automatic logic [CP_W-1:0] combine(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input logic [2:0] len);
    logic [CP_W-1:0] cp;
    case (len)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {14'd0, b0[6:0]};
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

### sv/utf8d_queue.sv
// ----------------------------------------------------------------------------
// utf8d_queue
// Short job queue between the byte front end and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_to_wide_char_decoder_top_defines.svh"

module utf8d_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  utf8d_pkg::job_t      job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output utf8d_pkg::job_t      job_o,
  output logic                 empty_o
);

  localparam int unsigned PTR_W = $clog2(utf8d_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(utf8d_pkg::QUEUE_DEPTH + 1);

  utf8d_pkg::job_t  mem_q [utf8d_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(utf8d_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(utf8d_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(utf8d_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `UTF8D_ASSERT_ALWAYS(a_no_overflow, !(push_i && full_o), "job pushed into a full queue")
  `UTF8D_ASSERT(a_no_underflow, !(pop_i && empty_o), "job popped from an empty queue")

endmodule

`default_nettype wire

### sv/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// Takes input bytes, assembles multi-byte sequences and turns each item that
// causes results into one queue job holding every result it causes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_to_wide_char_decoder_top_defines.svh"

module utf8d_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic                           operation_i,
  input  wire logic [7:0]                     in_byte_i,
  input  wire logic [utf8d_pkg::CAP_W-1:0]    cap_i,
  input  wire logic                           q_full_i,
  output logic                                q_push_o,
  output utf8d_pkg::job_t                     q_job_o
);

  logic [7:0]                   hb_q [3];
  logic [7:0]                   hb_d [3];
  logic [1:0]                   hc_q, hc_d;
  logic [2:0]                   sl_q, sl_d;
  logic [utf8d_pkg::SLOT_W-1:0] wc_q, wc_d;

  logic                         accept;
  logic [utf8d_pkg::CAP_W-1:0]  wc_next;
  logic [2:0]                   len;
  logic [7:0]                   asm [4];
  logic [7:0]                   ext [6];
  logic [2:0]                   pos;
  logic [2:0]                   ln;
  logic [1:0]                   n;
  logic [utf8d_pkg::SLOT_W-1:0] wc_l;
  logic [utf8d_pkg::CP_W-1:0]   cp;

  assign full_o  = q_full_i;
  assign accept  = push_i && !q_full_i;
  assign wc_next = {1'b0, wc_q} + 11'd1;
  assign len     = utf8d_pkg::lead_len(in_byte_i);

  always_comb begin
    hb_d     = hb_q;
    hc_d     = hc_q;
    sl_d     = sl_q;
    wc_d     = wc_q;
    q_push_o = 1'b0;
    q_job_o  = '0;
    pos      = 3'd0;
    ln       = 3'd0;
    n        = 2'd0;
    wc_l     = wc_q;
    cp       = '0;
    for (int k = 0; k < 4; k++) begin
      asm[k] = (k < 3 && 2'(k) < hc_q) ? hb_q[k % 3] : in_byte_i;
    end
    for (int k = 0; k < 6; k++) begin
      ext[k] = (k < 3) ? hb_q[k % 3] : 8'h00;
    end
    q_job_o.slot = wc_q;

    if (accept) begin
      if (operation_i == utf8d_pkg::OP_DATA) begin
        // bytes are dropped once the buffer only has room for the terminator
        if (wc_next < cap_i) begin
          if (hc_q == 2'd0) begin
            if (len == 3'd1) begin
              q_job_o.n_chars = 2'd1;
              q_job_o.cp0     = {13'd0, in_byte_i};
              q_push_o        = 1'b1;
              wc_d            = wc_q + 1'b1;
            end else if (len != 3'd0) begin
              hb_d[0] = in_byte_i;
              hc_d    = 2'd1;
              sl_d    = len;
            end
          end else if ({1'b0, hc_q} + 3'd1 >= sl_q) begin
            q_job_o.n_chars = 2'd1;
            q_job_o.cp0     = utf8d_pkg::combine(asm[0], asm[1], asm[2], asm[3],
                                                 {1'b0, hc_q} + 3'd1);
            q_push_o        = 1'b1;
            wc_d            = wc_q + 1'b1;
            hc_d            = 2'd0;
            sl_d            = 3'd0;
          end else begin
            if (hc_q == 2'd2) begin
              hb_d[2] = in_byte_i;
            end else begin
              hb_d[1] = in_byte_i;
            end
            hc_d = hc_q + 1'b1;
          end
        end
      end else begin
        // cut-off sequence: rescan held bytes as fresh leads
        for (int k = 0; k < 3; k++) begin
          if (pos == 3'(k) && 3'(k) < {1'b0, hc_q} && ({1'b0, wc_l} + 11'd1) < cap_i) begin
            ln = utf8d_pkg::lead_len(ext[k]);
            if (ln == 3'd0 || 3'(k) + ln > {1'b0, hc_q}) begin
              pos = 3'(k + 1);
            end else begin
              cp = utf8d_pkg::combine(ext[k], ext[k + 1], ext[k + 2], ext[k + 3], ln);
              if (n == 2'd0) begin
                q_job_o.cp0 = cp;
              end else begin
                q_job_o.cp1 = cp;
              end
              n    = n + 1'b1;
              wc_l = wc_l + 1'b1;
              pos  = 3'(k) + ln;
            end
          end
        end
        q_job_o.n_chars   = n;
        q_job_o.term      = (cap_i != '0);
        q_job_o.term_slot = ({1'b0, wc_l} < cap_i) ? wc_l
                                                   : utf8d_pkg::SLOT_W'(cap_i - 1'b1);
        q_push_o          = (n != 2'd0) || (cap_i != '0);
        for (int k = 0; k < 3; k++) begin
          hb_d[k] = 8'h00;
        end
        hc_d = 2'd0;
        sl_d = 3'd0;
        wc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        hb_q[k] <= 8'h00;
      end
      hc_q <= 2'd0;
      sl_q <= 3'd0;
      wc_q <= '0;
    end else begin
      hb_q <= hb_d;
      hc_q <= hc_d;
      sl_q <= sl_d;
      wc_q <= wc_d;
    end
  end

  `UTF8D_ASSERT(a_held_below_len, (hc_q == 2'd0) || (sl_q > {1'b0, hc_q}), "held bytes reach sequence length")

endmodule

`default_nettype wire

### sv/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// Expands queue jobs into single results and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_to_wide_char_decoder_top_defines.svh"

module utf8d_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_empty_i,
  input  utf8d_pkg::job_t                      q_job_i,
  output logic                                 q_pop_o,
  input  wire logic                            res_pop_i,
  output logic                                 res_empty_o,
  output logic [utf8d_pkg::CP_W-1:0]           code_point_o,
  output logic [utf8d_pkg::SLOT_W-1:0]         slot_index_o,
  output logic                                 is_terminator_o,
  output logic                                 last_of_run_o
);

  logic                         valid_q;
  logic [1:0]                   sub_q;
  logic [1:0]                   total;
  logic                         in_char;
  logic                         last;
  logic                         load;
  logic [utf8d_pkg::CP_W-1:0]   cp;
  logic [utf8d_pkg::SLOT_W-1:0] slot;

  assign total   = q_job_i.n_chars + {1'b0, q_job_i.term};
  assign in_char = (sub_q < q_job_i.n_chars);
  assign last    = (sub_q == total - 2'd1);
  // output register refills from a waiting job whenever it is empty or its beat leaves
  assign load    = !q_empty_i && (!valid_q || res_pop_i);
  assign q_pop_o = load && last;

  always_comb begin
    if (in_char) begin
      cp   = (sub_q == 2'd0) ? q_job_i.cp0 : q_job_i.cp1;
      slot = q_job_i.slot + utf8d_pkg::SLOT_W'(sub_q);
    end else begin
      cp   = '0;
      slot = q_job_i.term_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      sub_q   <= last ? 2'd0 : sub_q + 1'b1;
    end else if (res_pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_point_o    <= cp;
      slot_index_o    <= slot;
      is_terminator_o <= !in_char;
      last_of_run_o   <= last;
    end
  end

  assign res_empty_o = !valid_q;

  `UTF8D_ASSERT(a_sub_idle, !q_empty_i || (sub_q == 2'd0), "result index left over with no job")

endmodule

`default_nettype wire

### sv/utf8_to_wide_char_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_wide_char_decoder_top
// Lenient streaming UTF-8 decoder. Takes one byte or end mark per cycle while
// the job queue is not full; the front end turns every item that causes
// results into one job in a four-entry queue in the same cycle it is accepted,
// and the back end expands jobs into results, one per cycle while results are
// popped, through a registered output. A data byte gives at most one result,
// an end mark up to three (two rescued characters and the terminator), whose
// extra results the queue absorbs. The first result of an item passes the
// queue and then the output register before it reaches the result ports.
// Writing the capacity register takes effect on the next item; the user must
// write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_wide_char_decoder_top #(
  parameter int unsigned MAX_CAPACITY = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input queue side
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               operation_i,
  input  wire logic [7:0]                         in_byte_i,
  // result queue side
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [utf8d_pkg::CP_W-1:0]              code_point_o,
  output logic [utf8d_pkg::SLOT_W-1:0]            slot_index_o,
  output logic                                    is_terminator_o,
  output logic                                    last_of_run_o,
  // register port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [utf8d_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [utf8d_pkg::DATA_W-1:0]       pwdata,
  output logic [utf8d_pkg::DATA_W-1:0]            prdata,
  output logic                                    pready
);

  logic [utf8d_pkg::CAP_W-1:0]    capacity_q;
  logic [utf8d_pkg::CAP_W-1:0]    cap_eff;
  logic [utf8d_pkg::ADDR_W-3:0]   reg_idx;
  logic                           q_full;
  logic                           q_empty;
  logic                           q_push;
  logic                           q_pop;
  utf8d_pkg::job_t                q_job_in;
  utf8d_pkg::job_t                q_job_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[utf8d_pkg::ADDR_W-1:2];
  assign prdata  = (reg_idx == utf8d_pkg::REG_CAPACITY) ? utf8d_pkg::DATA_W'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= utf8d_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == utf8d_pkg::REG_CAPACITY) begin
      capacity_q <= pwdata[utf8d_pkg::CAP_W-1:0];
    end
  end

  // saturate to the largest buffer supported
  assign cap_eff = (32'(capacity_q) > 32'(MAX_CAPACITY)) ? utf8d_pkg::CAP_W'(MAX_CAPACITY)
                                                        : capacity_q;

  utf8d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .operation_i (operation_i),
    .in_byte_i   (in_byte_i),
    .cap_i       (cap_eff),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_job_in)
  );

  utf8d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_job_out),
    .empty_o (q_empty)
  );

  utf8d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_job_i         (q_job_out),
    .q_pop_o         (q_pop),
    .res_pop_i       (pop),
    .res_empty_o     (empty),
    .code_point_o    (code_point_o),
    .slot_index_o    (slot_index_o),
    .is_terminator_o (is_terminator_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire
